>>> src/audio_jitter_buffer_hysteresis_defines.svh
// Assertion macros shared by the jitter buffer RTL.
`ifndef AUDIO_JITTER_BUFFER_HYSTERESIS_DEFINES_SVH
`define AUDIO_JITTER_BUFFER_HYSTERESIS_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define AJBH_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition that must never be seen outside reset.
`define AJBH_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

>>> src/ajbh_pkg.sv
// Types and constants of the audio jitter buffer.
package ajbh_pkg;

   localparam int CSR_DATA_BITS = 12;
   localparam int CSR_INDEX_BITS = 3;
   localparam int LEVEL_BITS = 5;
   localparam int THRESH_BITS = 6;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BLOCK_LEN       = 3'd0,
      CSR_CAPACITY_BLOCKS = 3'd1,
      CSR_UNDERFLOW_ENTER = 3'd2,
      CSR_UNDERFLOW_EXIT  = 3'd3,
      CSR_OVERFLOW_RESUME = 3'd4
   } ajbh_csr_index_type;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } ajbh_op_type;

   typedef enum logic [1:0] {
      ST_PUSH_STORED  = 2'd0,
      ST_PUSH_DISCARD = 2'd1,
      ST_POP_DATA     = 2'd2,
      ST_POP_SILENCE  = 2'd3
   } ajbh_status_type;

   typedef enum logic {
      BK_RUN  = 1'b0,
      BK_READ = 1'b1
   } ajbh_back_state_type;

   typedef struct packed {
      logic               req_type;
      logic signed [31:0] sample_in;
   } ajbh_req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic signed [31:0]    sample_out;
      logic                  block_end;
      logic [LEVEL_BITS-1:0] level_blocks;
      logic                  in_underflow;
      logic                  in_overflow;
   } ajbh_rsp_type;

   typedef struct packed {
      ajbh_op_type        op;
      logic signed [31:0] sample;
   } ajbh_item_type;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0]  block_len;
      logic [LEVEL_BITS-1:0]     capacity_blocks;
      logic [THRESH_BITS-1:0]    underflow_enter;
      logic [THRESH_BITS-1:0]    underflow_exit;
      logic [THRESH_BITS-1:0]    overflow_resume;
   } ajbh_cfg_type;

endpackage

>>> src/ajbh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ajbh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/ajbh_front.sv
// Front end: accepts request beats, decodes push/pop and queues them.
module ajbh_front
   import ajbh_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  ajbh_req_type  req_data,
   output logic          q_valid,
   output ajbh_item_type q_item,
   input  logic          q_take
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   ajbh_item_type    slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_en;
   ajbh_item_type    item_dec;

   assign req_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push_en   = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      item_dec.op     = ajbh_op_type'(req_data.req_type);
      item_dec.sample = req_data.sample_in;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_take) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_en && !q_take) begin
         count_in = count_ff + 1'b1;
      end else if (!push_en && q_take) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         slot_ff[wr_ptr_ff] <= item_dec;
      end
   end

endmodule

>>> src/ajbh_back.sv
// Back end: ring pointers, hysteresis state, sample store and result register.
module ajbh_back
   import ajbh_pkg::*;
#(
   parameter int MAX_BLOCK_LEN = 2048,
   parameter int RING_BLOCKS   = 32,
   parameter int SAMPLE_BITS   = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  ajbh_cfg_type  cfg,
   input  logic          q_valid,
   input  ajbh_item_type q_item,
   output logic          q_take,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output ajbh_rsp_type  rsp_data
);

   localparam int OFF_W     = $clog2(MAX_BLOCK_LEN);
   localparam int LEN_W     = $clog2(MAX_BLOCK_LEN + 1);
   localparam int BLK_W     = $clog2(RING_BLOCKS);
   localparam int DEPTH     = RING_BLOCKS * MAX_BLOCK_LEN;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int CAP_LIMIT = (RING_BLOCKS - 1 < 31) ? RING_BLOCKS - 1 : 31;

   ajbh_back_state_type   state_ff, state_in;
   logic [BLK_W-1:0]      wr_blk_ff, wr_blk_in;
   logic [BLK_W-1:0]      rd_blk_ff, rd_blk_in;
   logic [OFF_W-1:0]      push_off_ff, push_off_in;
   logic [OFF_W-1:0]      pop_off_ff, pop_off_in;
   logic [LEVEL_BITS-1:0] fill_ff, fill_in;
   logic                  silence_ff, silence_in;
   logic                  discard_ff, discard_in;
   logic                  dropped_ff, dropped_in;
   logic                  silent_ff, silent_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ajbh_rsp_type          rsp_data_ff, rsp_data_in;
   ajbh_rsp_type          pend_ff, pend_in;

   logic [LEN_W-1:0]       len_eff;
   logic [LEVEL_BITS-1:0]  cap_eff;
   logic                   out_free;
   logic                   take;
   logic                   push_last, pop_last;
   logic                   p_drop, p_disc;
   logic                   q_quiet, q_silence;
   logic                   ram_we, ram_re;
   logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
   logic [SAMPLE_BITS-1:0] ram_rdata;
   logic [THRESH_BITS-1:0] fill_x;

   ajbh_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (q_item.sample[SAMPLE_BITS-1:0]),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign ram_waddr = ADDR_W'(wr_blk_ff) * ADDR_W'(MAX_BLOCK_LEN) + ADDR_W'(push_off_ff);
   assign ram_raddr = ADDR_W'(rd_blk_ff) * ADDR_W'(MAX_BLOCK_LEN) + ADDR_W'(pop_off_ff);

   // Clamp block length (zero counts as one) and capacity to what the ring can hold.
   always_comb begin
      if (cfg.block_len == '0) begin
         len_eff = LEN_W'(1);
      end else if (32'(cfg.block_len) > 32'(MAX_BLOCK_LEN)) begin
         len_eff = LEN_W'(MAX_BLOCK_LEN);
      end else begin
         len_eff = LEN_W'(cfg.block_len);
      end
      cap_eff = (32'(cfg.capacity_blocks) > 32'(CAP_LIMIT)) ? LEVEL_BITS'(CAP_LIMIT)
                                                           : cfg.capacity_blocks;
   end

   assign fill_x    = {1'b0, fill_ff};
   assign push_last = (LEN_W'(push_off_ff) + LEN_W'(1)) >= len_eff;
   assign pop_last  = (LEN_W'(pop_off_ff) + LEN_W'(1)) >= len_eff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign take      = (state_ff == BK_RUN) && q_valid && out_free;
   assign q_take    = take;

   // Push decision, taken at the first sample of a block.
   always_comb begin
      p_disc = discard_ff;
      p_drop = dropped_ff;
      if (push_off_ff == '0) begin
         p_drop = 1'b0;
         if (discard_ff) begin
            if (fill_x <= cfg.overflow_resume) begin
               p_disc = 1'b0;
            end else begin
               p_drop = 1'b1;
            end
         end
         if (!p_drop && fill_ff >= cap_eff) begin
            p_disc = 1'b1;
            p_drop = 1'b1;
         end
      end
   end

   // Pop decision, taken at the first sample of a block.
   always_comb begin
      q_silence = silence_ff;
      q_quiet   = silent_ff;
      if (pop_off_ff == '0) begin
         if (silence_ff) begin
            q_quiet = fill_x < cfg.underflow_exit;
            if (!q_quiet) begin
               q_silence = 1'b0;
            end
         end else begin
            q_quiet = fill_x < cfg.underflow_enter;
            if (q_quiet) begin
               q_silence = 1'b1;
            end
         end
         if (fill_ff == '0) begin
            q_quiet   = 1'b1;
            q_silence = 1'b1;
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_RUN: begin
            if (take && q_item.op == OP_POP && !q_quiet) begin
               state_in = BK_READ;
            end
         end
         BK_READ: begin
            if (out_free) begin
               state_in = BK_RUN;
            end
         end
         default: state_in = BK_RUN;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      wr_blk_in    = wr_blk_ff;
      rd_blk_in    = rd_blk_ff;
      push_off_in  = push_off_ff;
      pop_off_in   = pop_off_ff;
      fill_in      = fill_ff;
      silence_in   = silence_ff;
      discard_in   = discard_ff;
      dropped_in   = dropped_ff;
      silent_in    = silent_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      pend_in      = pend_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      unique case (state_ff)
         BK_RUN: begin
            if (take && q_item.op == OP_PUSH) begin
               ram_we     = !p_drop;
               discard_in = p_disc;
               dropped_in = p_drop;
               if (push_last) begin
                  push_off_in = '0;
                  if (!p_drop) begin
                     wr_blk_in = (wr_blk_ff == BLK_W'(RING_BLOCKS - 1)) ? '0
                                                                         : wr_blk_ff + 1'b1;
                     fill_in   = fill_ff + 1'b1;
                  end
               end else begin
                  push_off_in = push_off_ff + 1'b1;
               end
               rsp_valid_in             = 1'b1;
               rsp_data_in.status       = p_drop ? ST_PUSH_DISCARD : ST_PUSH_STORED;
               rsp_data_in.sample_out   = '0;
               rsp_data_in.block_end    = push_last;
               rsp_data_in.level_blocks = fill_in;
               rsp_data_in.in_underflow = silence_ff;
               rsp_data_in.in_overflow  = p_disc;
            end else if (take) begin
               silence_in = q_silence;
               silent_in  = q_quiet;
               if (pop_last) begin
                  pop_off_in = '0;
                  if (!q_quiet && fill_ff != '0) begin
                     rd_blk_in = (rd_blk_ff == BLK_W'(RING_BLOCKS - 1)) ? '0
                                                                         : rd_blk_ff + 1'b1;
                     fill_in   = fill_ff - 1'b1;
                  end
               end else begin
                  pop_off_in = pop_off_ff + 1'b1;
               end
               pend_in.status       = q_quiet ? ST_POP_SILENCE : ST_POP_DATA;
               pend_in.sample_out   = '0;
               pend_in.block_end    = pop_last;
               pend_in.level_blocks = fill_in;
               pend_in.in_underflow = q_silence;
               pend_in.in_overflow  = discard_ff;
               if (q_quiet) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = pend_in;
               end else begin
                  ram_re = 1'b1;
               end
            end
         end
         BK_READ: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in            = pend_ff;
               rsp_data_in.sample_out = 32'($signed(ram_rdata));
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_RUN;
         wr_blk_ff    <= '0;
         rd_blk_ff    <= '0;
         push_off_ff  <= '0;
         pop_off_ff   <= '0;
         fill_ff      <= '0;
         silence_ff   <= 1'b0;
         discard_ff   <= 1'b0;
         dropped_ff   <= 1'b0;
         silent_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_blk_ff    <= wr_blk_in;
         rd_blk_ff    <= rd_blk_in;
         push_off_ff  <= push_off_in;
         pop_off_ff   <= pop_off_in;
         fill_ff      <= fill_in;
         silence_ff   <= silence_in;
         discard_ff   <= discard_in;
         dropped_ff   <= dropped_in;
         silent_ff    <= silent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      pend_ff     <= pend_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> src/audio_jitter_buffer_hysteresis.sv
// Top level of the block-granular audio jitter buffer with hysteresis.
//
//   channel  dir  handshake          payload
//   req      in   req_valid/ready    ajbh_req_type  (push or pop one sample)
//   rsp      out  rsp_valid/ready    ajbh_rsp_type  (status, sample, level, flags)
//   csr      in   csr_write_en       csr_index, csr_wdata (no wait, no read-back)
//
// Push beats and silent pops go from the queue straight into the result
// register; pops that play stored data first read the sample store, whose read
// port is registered, and pass through BK_READ. A two-entry queue keeps taking
// beats while a result waits on rsp_ready; the back end holds until the result
// register frees, and req_ready drops once the queue is full.
// Synchronous reset clears pointers, level and flags and loads the config
// registers (1500, 19, 2, 10, 5); the sample store is not cleared.
module audio_jitter_buffer_hysteresis
   import ajbh_pkg::*;
#(
   parameter int MAX_BLOCK_LEN = 2048,
   parameter int RING_BLOCKS   = 32,
   parameter int SAMPLE_BITS   = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  ajbh_req_type              req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output ajbh_rsp_type              rsp_data,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

`include "audio_jitter_buffer_hysteresis_defines.svh"

   localparam int CAP_LIMIT = (RING_BLOCKS - 1 < 31) ? RING_BLOCKS - 1 : 31;

   ajbh_cfg_type  cfg_ff, cfg_in;
   logic          q_valid;
   ajbh_item_type q_item;
   logic          q_take;

   // Config register file; writes beyond the list fall through.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_BLOCK_LEN:       cfg_in.block_len       = csr_wdata;
            CSR_CAPACITY_BLOCKS: cfg_in.capacity_blocks = csr_wdata[LEVEL_BITS-1:0];
            CSR_UNDERFLOW_ENTER: cfg_in.underflow_enter = csr_wdata[THRESH_BITS-1:0];
            CSR_UNDERFLOW_EXIT:  cfg_in.underflow_exit  = csr_wdata[THRESH_BITS-1:0];
            CSR_OVERFLOW_RESUME: cfg_in.overflow_resume = csr_wdata[THRESH_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_len       <= CSR_DATA_BITS'(1500);
         cfg_ff.capacity_blocks <= LEVEL_BITS'(19);
         cfg_ff.underflow_enter <= THRESH_BITS'(2);
         cfg_ff.underflow_exit  <= THRESH_BITS'(10);
         cfg_ff.overflow_resume <= THRESH_BITS'(5);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Decode and queue incoming beats.
   ajbh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_take    (q_take)
   );

   // Ring state, hysteresis and the sample store.
   ajbh_back #(
      .MAX_BLOCK_LEN (MAX_BLOCK_LEN),
      .RING_BLOCKS   (RING_BLOCKS),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_take    (q_take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Level can never pass the usable ring size.
   `AJBH_ASSERT_NEVER(a_level_bound, rsp_valid && 32'(rsp_data.level_blocks) > 32'(CAP_LIMIT), "level beyond ring capacity")
   // Only a data pop carries a nonzero sample.
   `AJBH_ASSERT_IMPLY(a_zero_sample, rsp_valid && rsp_data.status != ST_POP_DATA, rsp_data.sample_out == '0, "nonzero sample on push or silence")
   // A discarded push only happens inside an overflow episode.
   `AJBH_ASSERT_IMPLY(a_drop_flag, rsp_valid && rsp_data.status == ST_PUSH_DISCARD, rsp_data.in_overflow, "discard without overflow episode")
   // Pop status agrees with the silence flag.
   `AJBH_ASSERT_IMPLY(a_pop_flag, rsp_valid && (rsp_data.status == ST_POP_DATA || rsp_data.status == ST_POP_SILENCE), rsp_data.in_underflow == (rsp_data.status == ST_POP_SILENCE), "pop status disagrees with silence flag")

endmodule
